FILE: hw/rtl/rep_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rep_pkg
// Shared types, widths and codes for the rumble envelope PWM driver.
// ============================================================================
package rep_pkg;

    // Field widths of the request and result words.
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned LVL_W      = 20;
    localparam int unsigned TIME_W     = 24;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned TICK_IDX_W = $clog2(TICK_W);

    // Q1.19 full scale and the widths of the interpolation arithmetic.
    localparam int unsigned FULL_SHIFT = 19;
    localparam int unsigned FULL_W     = TIME_W + FULL_SHIFT;
    localparam int unsigned PROD_W     = LVL_W + TIME_W;
    localparam int unsigned MIX_W      = PROD_W + 1;

    // Default number of PWM steps across the intensity range.
    localparam int unsigned PWM_STEPS_DEF = 8;

    // Largest remaining time, in Q8.16 seconds, that counts as a tenth of a second or less.
    localparam logic [TIME_W-1:0] TENTH_MAX = TIME_W'(6553);

    // Item kinds.
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_TICK    = 2'd0;
    localparam t_func FUNC_ADVANCE = 2'd1;
    localparam t_func FUNC_REQUEST = 2'd2;

    // Motor commands.
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_NONE  = 2'd0;
    localparam t_cmd CMD_START = 2'd1;
    localparam t_cmd CMD_STOP  = 2'd2;

    // Sequencer states for a tick.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_FROM,
        S_MUL_TO,
        S_MIX,
        S_REST,
        S_SCALE,
        S_DIV,
        S_MOD,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/rep_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rep_if
// Valid/ready channels carrying request words in and result words out.
// ============================================================================
interface rep_in_if;
    import rep_pkg::*;

    logic                valid;
    logic                ready;
    t_func               func;
    logic [TIME_W-1:0]   time_delta;
    logic [LVL_W-1:0]    start_level;
    logic [LVL_W-1:0]    end_level;
    logic [TIME_W-1:0]   duration;
    logic                blocked;

    modport source (
        output valid, func, time_delta, start_level, end_level, duration, blocked,
        input  ready
    );
    modport sink (
        input  valid, func, time_delta, start_level, end_level, duration, blocked,
        output ready
    );
endinterface

interface rep_out_if;
    import rep_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  motor_command;
    logic  motor_active;

    modport source (
        output valid, motor_command, motor_active,
        input  ready
    );
    modport sink (
        input  valid, motor_command, motor_active,
        output ready
    );
endinterface

FILE: hw/rtl/rumble_envelope_pwm.sv
`timescale 1ns / 1ps
// ============================================================================
// rumble_envelope_pwm
// Vibration motor driver with a linear intensity envelope and PWM on ticks.
// ============================================================================
// Some words have their result word registered at once: advance words,
// request words, ticks with no running envelope, and all words while
// disabled. A tick on a running envelope takes longer. Set-up runs two
// products on one multiplier, then mix, remainder and scaling. The period
// division then runs by repeated subtraction. When the period exceeds one, a
// bit-serial modulo of the tick counter follows. A final state loads the
// result word, and a receiver stall on the result word holds it there. The
// division and the modulo both run on one shared add/subtract unit. The
// block takes no new word while a tick is at work.
module rumble_envelope_pwm #(
    parameter int unsigned PWM_STEPS = rep_pkg::PWM_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    rep_in_if.sink    i_req,
    rep_out_if.source o_rsp
);
    import rep_pkg::*;

    localparam int unsigned Q_W   = $clog2(PWM_STEPS + 1);
    localparam int unsigned PER_W = $clog2(PWM_STEPS + 2);
    localparam int unsigned REM_W = $clog2(2 * PWM_STEPS + 2);
    localparam int unsigned TGT_W = FULL_W + Q_W;
    localparam int unsigned ALU_W = (TGT_W > MIX_W) ? TGT_W : MIX_W;
    localparam logic [TGT_W-1:0] STEPS_K = TGT_W'(PWM_STEPS);

    // Control and envelope state.
    t_state              r_state, n_state;
    logic                r_enable;
    logic [TICK_W-1:0]   r_tick;
    logic                r_motor;
    logic [TIME_W-1:0]   r_len;
    logic [TIME_W-1:0]   r_el;
    logic [LVL_W-1:0]    r_from;
    logic [LVL_W-1:0]    r_to;

    // Working registers of the tick sequence.
    logic [TIME_W-1:0]   r_span;
    logic [PROD_W-1:0]   r_prod;
    logic [ALU_W-1:0]    r_acc;
    logic [Q_W-1:0]      r_q;
    logic [REM_W-1:0]    r_rem;
    logic [TICK_W-1:0]   r_bits;
    logic [TICK_IDX_W-1:0] r_cnt;
    logic                r_want;

    // Output register.
    logic                r_out_valid;
    t_cmd                r_out_cmd;
    logic                r_out_active;

    // Handshake.
    logic                out_free;
    logic                in_accept;
    logic                env_running;
    logic                tick_go;

    // Shared add/subtract unit.
    logic [ALU_W-1:0]    alu_a, alu_b;
    logic                alu_sub;
    logic [ALU_W:0]      alu_res;
    logic                alu_ge;

    // Multiplier.
    logic [LVL_W-1:0]    mul_a;
    logic [TIME_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;

    // Misc datapath.
    logic [ALU_W-1:0]    full_ext;
    logic [TGT_W-1:0]    target;
    logic [PER_W-1:0]    period;
    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    rem_next;
    logic [TIME_W:0]     adv_sum;
    logic [TIME_W-1:0]   req_rem;
    logic                req_short;
    logic                req_strong;
    logic                req_take;

    // Result loading.
    logic                out_load;
    logic                out_tick;
    logic                out_want;

    // Handshake and the test for a running envelope.
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign in_accept   = i_req.valid && i_req.ready;
    assign env_running = r_el < r_len;
    assign tick_go     = in_accept && r_enable && (i_req.func == FUNC_TICK) && env_running;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.motor_command = r_out_cmd;
    assign o_rsp.motor_active  = r_out_active;

    // Operands that the sequence derives from state.
    assign full_ext  = ALU_W'({r_len, {FULL_SHIFT{1'b0}}});
    assign target    = TGT_W'(r_acc[FULL_W-1:0]) * STEPS_K;
    assign period    = PER_W'(r_q) + PER_W'(1);
    assign rem_shift = {r_rem[REM_W-2:0], r_bits[TICK_W-1]};

    // One multiplier, shared by the two envelope products.
    assign mul_a = (r_state == S_MUL_FROM) ? r_from : r_to;
    assign mul_b = (r_state == S_MUL_FROM) ? r_span : r_el;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Shared adder: the sum is one bit wider, and that bit is the no-borrow flag.
    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ALU_W + 1)'(alu_sub);
    assign alu_ge  = alu_res[ALU_W];
    assign rem_next = alu_ge ? alu_res[REM_W-1:0] : rem_shift;

    // Advance and request decisions are small and settle in the accepting cycle.
    assign adv_sum    = {1'b0, r_el} + {1'b0, i_req.time_delta};
    assign req_rem    = (r_len >= r_el) ? (r_len - r_el) : '0;
    assign req_short  = req_rem <= TENTH_MAX;
    assign req_strong = ({1'b0, i_req.start_level} + {1'b0, i_req.end_level})
                        >= ({1'b0, r_from} + {1'b0, r_to});
    assign req_take   = (i_req.duration != '0) && !i_req.blocked && (req_short || req_strong);

    // Next state of the tick sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_go) n_state = S_MUL_FROM;
            end
            S_MUL_FROM: n_state = S_MUL_TO;
            S_MUL_TO:   n_state = S_MIX;
            S_MIX:      n_state = S_REST;
            S_REST:     n_state = S_SCALE;
            S_SCALE:    n_state = S_DIV;
            S_DIV: begin
                if (!alu_ge) n_state = (r_q == '0) ? S_DONE : S_MOD;
            end
            S_MOD: begin
                if (r_cnt == TICK_IDX_W'(TICK_W - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Operand selection for the shared unit and result loading, by state.
    always_comb begin
        alu_a    = '0;
        alu_b    = '0;
        alu_sub  = 1'b0;
        out_load = 1'b0;
        out_tick = 1'b0;
        out_want = 1'b0;
        case (r_state)
            S_IDLE: begin
                // Every word but a tick on a running envelope answers at once.
                out_load = in_accept && !tick_go;
                out_tick = r_enable && (i_req.func == FUNC_TICK);
            end
            S_MIX: begin
                alu_a = r_acc;
                alu_b = ALU_W'(r_prod);
            end
            S_REST: begin
                alu_a   = full_ext;
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = r_acc;
                alu_b   = full_ext;
                alu_sub = 1'b1;
            end
            S_MOD: begin
                alu_a   = ALU_W'(rem_shift);
                alu_b   = ALU_W'(period);
                alu_sub = 1'b1;
            end
            S_DONE: begin
                out_load = out_free;
                out_tick = 1'b1;
                out_want = r_want;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Sequencer state, envelope state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tick       <= '0;
            r_motor      <= 1'b0;
            r_len        <= '0;
            r_el         <= '0;
            r_from       <= '0;
            r_to         <= '0;
            r_out_valid  <= 1'b0;
            r_out_cmd    <= CMD_NONE;
            r_out_active <= 1'b0;
        end else begin
            r_state <= n_state;

            // Envelope updates from the accepted word.
            if (in_accept && r_enable) begin
                case (i_req.func)
                    FUNC_TICK: r_tick <= r_tick + TICK_W'(1);
                    FUNC_ADVANCE: begin
                        r_el <= (adv_sum > {1'b0, r_len}) ? r_len : adv_sum[TIME_W-1:0];
                    end
                    FUNC_REQUEST: begin
                        if (req_take) begin
                            r_len  <= i_req.duration;
                            r_el   <= '0;
                            r_from <= i_req.start_level;
                            r_to   <= i_req.end_level;
                        end
                    end
                    default: r_tick <= r_tick;
                endcase
            end

            // Result word: a tick reports a change of the motor's on state.
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (out_tick) begin
                    r_motor      <= out_want;
                    r_out_active <= out_want;
                    if (out_want == r_motor) begin
                        r_out_cmd <= CMD_NONE;
                    end else begin
                        r_out_cmd <= out_want ? CMD_START : CMD_STOP;
                    end
                end else begin
                    r_out_cmd    <= CMD_NONE;
                    r_out_active <= r_motor;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the tick sequence.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_span <= r_len - r_el;
                r_bits <= r_tick + TICK_W'(1);
                r_want <= 1'b0;
            end
            S_MUL_FROM: r_prod <= mul_p;
            S_MUL_TO: begin
                r_acc  <= ALU_W'(r_prod);
                r_prod <= mul_p;
            end
            S_MIX:  r_acc <= alu_res[ALU_W-1:0];
            S_REST: r_acc <= alu_ge ? alu_res[ALU_W-1:0] : '0;
            S_SCALE: begin
                r_acc <= ALU_W'(target);
                r_q   <= '0;
            end
            S_DIV: begin
                if (alu_ge) begin
                    r_acc <= alu_res[ALU_W-1:0];
                    r_q   <= r_q + Q_W'(1);
                end else begin
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_want <= (r_q == '0);
                end
            end
            S_MOD: begin
                r_rem  <= rem_next;
                r_bits <= {r_bits[TICK_W-2:0], 1'b0};
                r_cnt  <= r_cnt + TICK_IDX_W'(1);
                if (r_cnt == TICK_IDX_W'(TICK_W - 1)) r_want <= (rem_next == '0);
            end
            default: r_want <= r_want;
        endcase
    end

`ifndef SYNTH
    // Elapsed time never runs past the envelope length.
    a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_el <= r_len)
        else $error("elapsed time beyond envelope length");

    // The period quotient cannot exceed the number of PWM steps.
    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_q <= Q_W'(PWM_STEPS)))
        else $error("period quotient out of range");

    // The running remainder of the modulo stays below the period.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_rem < REM_W'(period)))
        else $error("modulo remainder not below period");

    // A start or stop command always agrees with the reported on state.
    a_cmd_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd != CMD_NONE) |->
        ((r_out_cmd == CMD_START) == r_out_active))
        else $error("motor command disagrees with on state");
`endif

endmodule
